[hdl/ofva_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the oldest-first voice allocator.
// No dependencies.
package ofva_pkg;

    localparam int unsigned VOICES_DEF = 64;
    localparam int unsigned PARTS      = 16;
    localparam int unsigned LIMIT_W    = 7;
    localparam int unsigned AGE_W      = 64;
    localparam int unsigned IDX_XW     = 9;     // wide enough for any slot index or limit
    localparam int unsigned MASK_W     = 64;
    localparam int unsigned COUNT_W    = 7;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        FN_NOTE_ON  = 2'd0,
        FN_NOTE_OFF = 2'd1,
        FN_DONE     = 2'd2,
        FN_CLEAR    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOMATCH = 2'd1,
        STAT_LIMIT   = 2'd2
    } stat_t;

    typedef struct packed {
        logic [3:0]       part;
        logic [6:0]       key;
        logic [7:0]       group;
        logic [AGE_W-1:0] age;
    } entry_t;

    typedef struct packed {
        logic grp_hit;
        logic key_hit;
        logic older;
    } cmp_t;

endpackage

[hdl/ofva_req_if.sv]
`timescale 1ns / 1ps
// Request channel: one item per note event.
// No dependencies.
interface ofva_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [3:0] part;
    logic [6:0] note_key;
    logic [7:0] new_group;
    logic [7:0] release_group;
    logic [5:0] done_slot;

    modport source (
        output valid, func, part, note_key, new_group, release_group, done_slot,
        input  ready
    );
    modport sink (
        input  valid, func, part, note_key, new_group, release_group, done_slot,
        output ready
    );
endinterface

[hdl/ofva_rsp_if.sv]
`timescale 1ns / 1ps
// Response channel: one result item per request item.
// No dependencies.
interface ofva_rsp_if;
    logic        valid;
    logic        ready;
    logic [5:0]  chosen_slot;
    logic        stolen;
    logic [63:0] release_mask;
    logic [6:0]  release_count;
    logic [1:0]  status;

    modport source (
        output valid, chosen_slot, stolen, release_mask, release_count, status,
        input  ready
    );
    modport sink (
        input  valid, chosen_slot, stolen, release_mask, release_count, status,
        output ready
    );
endinterface

[hdl/ofva_slot_ram.sv]
`timescale 1ns / 1ps
// Per-slot voice table (part, key, group, start age), one write and one
// registered read port. Depends on ofva_pkg.
module ofva_slot_ram #(
    parameter int unsigned VOICES = ofva_pkg::VOICES_DEF
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] waddr,
    input  ofva_pkg::entry_t                            wdata,
    input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] raddr,
    output ofva_pkg::entry_t                            rdata
);

    ofva_pkg::entry_t mem [VOICES];
    ofva_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/ofva_slot_cmp.sv]
`timescale 1ns / 1ps
// Shared slot compare unit: group match, key match and age order for the
// slot under scan. Depends on ofva_pkg.
module ofva_slot_cmp (
    input  ofva_pkg::entry_t                 entry,
    input  logic                             busy,
    input  logic                             held,
    input  logic [3:0]                       part,
    input  logic [6:0]                       note_key,
    input  logic [7:0]                       release_group,
    input  logic [ofva_pkg::AGE_W-1:0]       best_age,
    output ofva_pkg::cmp_t                   result
);

    always_comb
    begin
        result.grp_hit = busy && (release_group != 8'd0) && (entry.group == release_group);
        result.key_hit = busy && held && (entry.part == part) && (entry.key == note_key);
        result.older   = entry.age < best_age;
    end

endmodule

[hdl/oldest_first_voice_allocator.sv]
`timescale 1ns / 1ps
// Oldest-first voice allocator: top level with sequencer, slot flags and
// response register. Depends on ofva_pkg, ofva_req_if, ofva_rsp_if,
// ofva_slot_ram and ofva_slot_cmp.
//
// Usage:
//   req carries note-on, note-off, voice-finished and clear items; rsp gives
//   one result item per request (chosen slot, steal flag, released slots,
//   release count, status). cfg_we/cfg_wdata write the voice limit; the user
//   must do so only while the block is idle, which the block does not check.
//   A value of zero or above VOICES is dropped, and slots at or above the new
//   limit are freed at once. Note-on and note-off scan every slot through one
//   compare unit, one slot per cycle behind the table's registered read; the
//   result becomes valid in the same cycle as req.ready returns. Finished
//   and clear items skip the scan and go straight to the commit state.
//   req.ready is high only while no item is in work. A finished result sits
//   in the response register; the next item may be accepted and worked on
//   while it waits, and its own result waits until rsp.ready takes the old.
//   Reset frees all slots, zeroes the age counter and sets the limit to
//   min(64, VOICES); the slot table needs no clearing pass since entries are
//   read only for busy slots.
module oldest_first_voice_allocator #(
    parameter int unsigned VOICES = ofva_pkg::VOICES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ofva_req_if.sink                      req,
    ofva_rsp_if.source                    rsp,
    input  logic                          cfg_we,
    input  logic [ofva_pkg::LIMIT_W-1:0]  cfg_wdata
);

    localparam int unsigned IW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int unsigned CW = $clog2(VOICES + 1);
    localparam int unsigned XW = ofva_pkg::IDX_XW;
    localparam int unsigned AW = ofva_pkg::AGE_W;
    localparam int unsigned NW = ofva_pkg::COUNT_W;
    localparam int unsigned MW = ofva_pkg::MASK_W;
    localparam logic [ofva_pkg::LIMIT_W-1:0] LIMIT_RST =
        ofva_pkg::LIMIT_W'((VOICES < 64) ? VOICES : 64);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_COMMIT = 4'b0100,
        ST_RESP   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    ofva_pkg::func_t func_reg, func_next;
    logic [3:0] part_reg, part_next;
    logic [6:0] key_reg, key_next;
    logic [7:0] ngrp_reg, ngrp_next;
    logic [7:0] rgrp_reg, rgrp_next;
    logic [5:0] done_reg, done_next;

    logic [ofva_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    logic [VOICES-1:0] busy_reg, busy_next;
    logic [VOICES-1:0] held_reg, held_next;
    logic [AW-1:0] age_reg, age_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic pv_reg, pv_next;
    logic [IW-1:0] pidx_reg, pidx_next;
    logic found_reg, found_next;
    logic [IW-1:0] free_reg, free_next;
    logic [IW-1:0] old_reg, old_next;
    logic [AW-1:0] old_age_reg, old_age_next;

    logic [5:0] res_chosen_reg, res_chosen_next;
    logic res_stolen_reg, res_stolen_next;
    logic [MW-1:0] res_mask_reg, res_mask_next;
    logic [NW-1:0] res_count_reg, res_count_next;
    ofva_pkg::stat_t res_status_reg, res_status_next;

    logic out_valid_reg, out_valid_next;
    logic [5:0] out_chosen_reg, out_chosen_next;
    logic out_stolen_reg, out_stolen_next;
    logic [MW-1:0] out_mask_reg, out_mask_next;
    logic [NW-1:0] out_count_reg, out_count_next;
    ofva_pkg::stat_t out_status_reg, out_status_next;

    ofva_pkg::entry_t rd_entry;
    ofva_pkg::entry_t wr_entry;
    ofva_pkg::cmp_t cmp;
    logic ram_we;
    logic [IW-1:0] ch_idx;
    logic [XW-1:0] ch_ext;
    logic [XW-1:0] pext;
    logic [XW-1:0] done_ext;
    logic [XW-1:0] limit_ext;
    logic [XW-1:0] cfg_ext;
    logic in_lim;
    logic pbusy;
    logic pheld;
    logic part_ok;
    logic issue;
    logic accept;
    logic cfg_ok;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign issue     = cnt_reg < CW'(VOICES);
    assign pext      = XW'(pidx_reg);
    assign limit_ext = XW'(limit_reg);
    assign done_ext  = XW'(done_reg);
    assign cfg_ext   = XW'(cfg_wdata);
    assign in_lim    = pext < limit_ext;
    assign pbusy     = busy_reg[pidx_reg];
    assign pheld     = held_reg[pidx_reg];
    assign part_ok   = 32'(part_reg) < ofva_pkg::PARTS;
    assign cfg_ok    = (cfg_wdata != '0) && (cfg_ext <= XW'(VOICES));
    assign ch_idx    = found_reg ? free_reg : old_reg;
    assign ch_ext    = XW'(ch_idx);
    assign ram_we    = (state_reg == ST_COMMIT) && (func_reg == ofva_pkg::FN_NOTE_ON) && part_ok;

    always_comb
    begin
        wr_entry.part  = part_reg;
        wr_entry.key   = key_reg;
        wr_entry.group = ngrp_reg;
        wr_entry.age   = age_reg + AW'(1);
    end

    ofva_slot_ram #(
        .VOICES (VOICES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ch_idx),
        .wdata (wr_entry),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (rd_entry)
    );

    ofva_slot_cmp u_cmp (
        .entry         (rd_entry),
        .busy          (pbusy),
        .held          (pheld),
        .part          (part_reg),
        .note_key      (key_reg),
        .release_group (rgrp_reg),
        .best_age      (old_age_reg),
        .result        (cmp)
    );

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        part_next       = part_reg;
        key_next        = key_reg;
        ngrp_next       = ngrp_reg;
        rgrp_next       = rgrp_reg;
        done_next       = done_reg;
        limit_next      = limit_reg;
        busy_next       = busy_reg;
        held_next       = held_reg;
        age_next        = age_reg;
        cnt_next        = cnt_reg;
        pv_next         = 1'b0;
        pidx_next       = pidx_reg;
        found_next      = found_reg;
        free_next       = free_reg;
        old_next        = old_reg;
        old_age_next    = old_age_reg;
        res_chosen_next = res_chosen_reg;
        res_stolen_next = res_stolen_reg;
        res_mask_next   = res_mask_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_chosen_next = out_chosen_reg;
        out_stolen_next = out_stolen_reg;
        out_mask_next   = out_mask_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;

        if (cfg_we && cfg_ok)
        begin
            limit_next = cfg_wdata;
            for (int i = 0; i < VOICES; i++)
            begin
                if (XW'(i) >= cfg_ext)
                begin
                    busy_next[i] = 1'b0;
                    held_next[i] = 1'b0;
                end
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next       = ofva_pkg::func_t'(req.func);
                    part_next       = req.part;
                    key_next        = req.note_key;
                    ngrp_next       = req.new_group;
                    rgrp_next       = req.release_group;
                    done_next       = req.done_slot;
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    res_chosen_next = '0;
                    res_stolen_next = 1'b0;
                    res_mask_next   = '0;
                    res_count_next  = '0;
                    res_status_next = ofva_pkg::STAT_OK;
                    if (((req.func == ofva_pkg::FN_NOTE_ON) || (req.func == ofva_pkg::FN_NOTE_OFF))
                        && (32'(req.part) < ofva_pkg::PARTS))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    cnt_next  = cnt_reg + CW'(1);
                    pv_next   = 1'b1;
                    pidx_next = cnt_reg[IW-1:0];
                end
                if (pv_reg)
                begin
                    if (func_reg == ofva_pkg::FN_NOTE_ON)
                    begin
                        if (cmp.grp_hit)
                        begin
                            if (pext < XW'(MW))
                            begin
                                res_mask_next[pext[5:0]] = 1'b1;
                            end
                            if (res_count_reg != ofva_pkg::COUNT_MAX)
                            begin
                                res_count_next = res_count_reg + NW'(1);
                            end
                        end
                        if (in_lim && !found_reg)
                        begin
                            if (!pbusy)
                            begin
                                found_next = 1'b1;
                                free_next  = pidx_reg;
                            end
                            else if ((pidx_reg == '0) || cmp.older)
                            begin
                                old_next     = pidx_reg;
                                old_age_next = rd_entry.age;
                            end
                        end
                    end
                    else if (cmp.key_hit)
                    begin
                        held_next[pidx_reg] = 1'b0;
                        if (pext < XW'(MW))
                        begin
                            res_mask_next[pext[5:0]] = 1'b1;
                        end
                        if (res_count_reg != ofva_pkg::COUNT_MAX)
                        begin
                            res_count_next = res_count_reg + NW'(1);
                        end
                    end
                end
                if (!issue && !pv_reg)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_RESP;
                unique case (func_reg)
                    ofva_pkg::FN_NOTE_ON:
                    begin
                        if (!part_ok)
                        begin
                            res_status_next = ofva_pkg::STAT_NOMATCH;
                        end
                        else
                        begin
                            res_chosen_next   = ch_ext[5:0];
                            res_stolen_next   = !found_reg;
                            age_next          = age_reg + AW'(1);
                            busy_next[ch_idx] = 1'b1;
                            held_next[ch_idx] = 1'b1;
                        end
                    end
                    ofva_pkg::FN_NOTE_OFF:
                    begin
                        if (res_count_reg == '0)
                        begin
                            res_status_next = ofva_pkg::STAT_NOMATCH;
                        end
                    end
                    ofva_pkg::FN_DONE:
                    begin
                        if ((done_ext >= limit_ext) || (done_ext >= XW'(VOICES)))
                        begin
                            res_status_next = ofva_pkg::STAT_LIMIT;
                        end
                        else if (!busy_reg[done_ext[IW-1:0]])
                        begin
                            res_status_next = ofva_pkg::STAT_NOMATCH;
                        end
                        else
                        begin
                            busy_next[done_ext[IW-1:0]] = 1'b0;
                            held_next[done_ext[IW-1:0]] = 1'b0;
                        end
                    end
                    ofva_pkg::FN_CLEAR:
                    begin
                        busy_next = '0;
                        held_next = '0;
                        age_next  = '0;
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_chosen_next = res_chosen_reg;
                    out_stolen_next = res_stolen_reg;
                    out_mask_next   = res_mask_reg;
                    out_count_next  = res_count_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= LIMIT_RST;
            busy_reg      <= '0;
            held_reg      <= '0;
            age_reg       <= '0;
            cnt_reg       <= '0;
            pv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            busy_reg      <= busy_next;
            held_reg      <= held_next;
            age_reg       <= age_next;
            cnt_reg       <= cnt_next;
            pv_reg        <= pv_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        part_reg        <= part_next;
        key_reg         <= key_next;
        ngrp_reg        <= ngrp_next;
        rgrp_reg        <= rgrp_next;
        done_reg        <= done_next;
        pidx_reg        <= pidx_next;
        free_reg        <= free_next;
        old_reg         <= old_next;
        old_age_reg     <= old_age_next;
        res_chosen_reg  <= res_chosen_next;
        res_stolen_reg  <= res_stolen_next;
        res_mask_reg    <= res_mask_next;
        res_count_reg   <= res_count_next;
        res_status_reg  <= res_status_next;
        out_chosen_reg  <= out_chosen_next;
        out_stolen_reg  <= out_stolen_next;
        out_mask_reg    <= out_mask_next;
        out_count_reg   <= out_count_next;
        out_status_reg  <= out_status_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.chosen_slot   = out_chosen_reg;
    assign rsp.stolen        = out_stolen_reg;
    assign rsp.release_mask  = out_mask_reg;
    assign rsp.release_count = out_count_reg;
    assign rsp.status        = out_status_reg;

endmodule

[hdl/ofva_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the oldest-first voice allocator, bound to the top.
// Depends on ofva_pkg and oldest_first_voice_allocator.
module ofva_checker #(
    parameter int unsigned VOICES = ofva_pkg::VOICES_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [5:0]  chosen_slot,
    input logic        stolen,
    input logic [63:0] release_mask,
    input logic [6:0]  release_count,
    input logic [1:0]  status
);

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while an item is in work");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(release_mask)
            && $stable(status) && $stable(chosen_slot)))
        else $error("stalled result changed");

    a_count_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        ((VOICES <= 64) && rsp_valid) |-> (32'(release_count) == $countones(release_mask)))
        else $error("release count disagrees with mask");

    a_steal_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && stolen) |-> (status == ofva_pkg::STAT_OK))
        else $error("steal reported with bad status");

    a_limit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == ofva_pkg::STAT_LIMIT)) |->
            ((release_mask == '0) && (chosen_slot == '0) && !stolen && (release_count == '0)))
        else $error("out-of-limit result carries data");

endmodule

bind oldest_first_voice_allocator ofva_checker #(
    .VOICES (VOICES)
) u_ofva_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .chosen_slot   (rsp.chosen_slot),
    .stolen        (rsp.stolen),
    .release_mask  (rsp.release_mask),
    .release_count (rsp.release_count),
    .status        (rsp.status)
);
